>>> design/wlevd_pkg.sv
// Shared types, codes and defaults for the windowed light event detector.
package wlevd_pkg;

	localparam int DEF_WINDOW_DEPTH = 16;
	localparam int DEF_EVENT_SLOTS  = 8;

	localparam int CMD_W    = 2;
	localparam int SMP_W    = 32;
	localparam int CNT_W    = 16;
	localparam int SLOT_W   = 3;
	localparam int MASK_W   = 8;
	localparam int STATUS_W = 2;
	localparam int MARGIN_W = 16;

	localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

	localparam logic [MARGIN_W-1:0] NOISE_MARGIN_RST = 16'd20;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic signed [SMP_W-1:0]  intensity;
		logic signed [SMP_W-1:0]  required_intensity;
		logic [CNT_W-1:0]         min_count;
		logic [SLOT_W-1:0]        event_slot;
	} request_t;

	typedef struct packed {
		logic [MASK_W-1:0]   fired_mask;
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   new_slot;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic rd_en;
		logic finish;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_sample;
		logic rd_last;
	} dp_status_t;

endpackage

>>> design/wlevd_ctrl.sv
// Controller state machine: accept, ring scan, drain and finish sequencing.
module wlevd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  wlevd_pkg::dp_status_t sts,
	output wlevd_pkg::ctl_cmd_t   cmd,
	output logic                  busy
);
	import wlevd_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.rd_en  = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (sts.is_sample) state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (sts.rd_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> design/wlevd_datapath.sv
// Datapath: sample ring memory, slot table, per-slot hit counters, result register.
module wlevd_datapath #(
	parameter int WINDOW_DEPTH = wlevd_pkg::DEF_WINDOW_DEPTH,
	parameter int EVENT_SLOTS  = wlevd_pkg::DEF_EVENT_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wlevd_pkg::ctl_cmd_t              cmd,
	output wlevd_pkg::dp_status_t            sts,
	input  wlevd_pkg::request_t              request,
	input  logic                             cfg_wr,
	input  logic [wlevd_pkg::MARGIN_W-1:0]   cfg_data,
	output wlevd_pkg::result_t               result,
	output logic                             done
);
	import wlevd_pkg::*;

	localparam int AW     = $clog2(WINDOW_DEPTH);
	localparam int FW     = $clog2(WINDOW_DEPTH + 1);
	localparam int MASK_N = (EVENT_SLOTS < MASK_W) ? EVENT_SLOTS : MASK_W;

	logic [MARGIN_W-1:0]      margin_q;
	logic signed [SMP_W-1:0]  ring [WINDOW_DEPTH];
	logic signed [SMP_W-1:0]  rd_data_s1;
	logic                     rd_vld_s1;
	logic [AW-1:0]            wpos_q;
	logic [AW-1:0]            addr_q;
	logic [FW-1:0]            fill_q;

	logic [EVENT_SLOTS-1:0]   valid_q;
	logic signed [SMP_W-1:0]  thr_q   [EVENT_SLOTS];
	logic [FW-1:0]            minh_q  [EVENT_SLOTS];
	logic [FW-1:0]            hits_q  [EVENT_SLOTS];

	result_t                  res_q;
	logic                     done_q;

	logic                     is_create;
	logic                     is_destroy;
	logic                     smp_wr;
	logic [EVENT_SLOTS-1:0]   free_oh;
	logic                     free_found;
	logic [SLOT_W-1:0]        free_slot;
	logic [EVENT_SLOTS-1:0]   kill_oh;
	logic                     kill_ok;
	logic [FW-1:0]            min_clamped;
	logic [EVENT_SLOTS-1:0]   hit;
	logic [MASK_W-1:0]        mask;
	logic [STATUS_W-1:0]      acc_status;
	logic [SLOT_W-1:0]        acc_slot;

	assign sts.is_sample = (request.command == CMD_SAMPLE);
	assign sts.rd_last   = ((FW'(addr_q) + FW'(1)) == fill_q);

	assign is_create  = cmd.accept && (request.command == CMD_CREATE);
	assign is_destroy = cmd.accept && (request.command == CMD_DESTROY);
	assign smp_wr     = cmd.accept && sts.is_sample;

	// lowest free slot
	assign free_oh    = ~valid_q & (valid_q + EVENT_SLOTS'(1));
	assign free_found = |free_oh;

	always_comb begin
		free_slot = '0;
		kill_oh   = '0;
		for (int s = 0; s < EVENT_SLOTS; s++) begin
			if (free_oh[s]) free_slot = SLOT_W'(s);
			kill_oh[s] = valid_q[s] && (32'(request.event_slot) == s);
		end
	end
	assign kill_ok = |kill_oh;

	assign min_clamped = (32'(request.min_count) > WINDOW_DEPTH) ?
		FW'(WINDOW_DEPTH) : FW'(request.min_count);

	// window entry against each slot's limit, 33-bit signed
	always_comb begin
		logic signed [SMP_W:0] smp;
		logic signed [SMP_W:0] lim;
		smp = {rd_data_s1[SMP_W-1], rd_data_s1};
		for (int s = 0; s < EVENT_SLOTS; s++) begin
			lim    = $signed({thr_q[s][SMP_W-1], thr_q[s]}) -
				$signed({1'b0, {(SMP_W-MARGIN_W){1'b0}}, margin_q});
			hit[s] = (smp > lim);
		end
	end

	always_comb begin
		mask = '0;
		for (int s = 0; s < MASK_N; s++) begin
			mask[s] = valid_q[s] && (hits_q[s] >= minh_q[s]);
		end
	end

	always_comb begin
		acc_status = ST_OK;
		acc_slot   = '0;
		unique case (request.command)
			CMD_CREATE: begin
				if (free_found) acc_slot = free_slot;
				else acc_status = ST_FULL;
			end
			CMD_DESTROY: begin
				if (!kill_ok) acc_status = ST_UNKNOWN;
			end
			default: begin
				acc_status = ST_OK;
			end
		endcase
	end

	// ring memory
	always_ff @(posedge clk) begin
		if (smp_wr) ring[wpos_q] <= request.intensity;
		rd_data_s1 <= ring[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q  <= NOISE_MARGIN_RST;
			wpos_q    <= '0;
			fill_q    <= '0;
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			valid_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_wr) margin_q <= cfg_data;
			rd_vld_s1 <= cmd.rd_en;
			if (smp_wr) begin
				wpos_q <= (wpos_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wpos_q + AW'(1);
				if (fill_q != FW'(WINDOW_DEPTH)) fill_q <= fill_q + FW'(1);
				addr_q <= '0;
			end else if (cmd.rd_en) begin
				addr_q <= addr_q + AW'(1);
			end
			if (is_create && free_found) valid_q <= valid_q | free_oh;
			if (is_destroy) valid_q <= valid_q & ~kill_oh;
			done_q <= (cmd.accept && !sts.is_sample) || cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < EVENT_SLOTS; s++) begin
			if (is_create && free_oh[s]) begin
				thr_q[s]  <= request.required_intensity;
				minh_q[s] <= min_clamped;
			end
			if (smp_wr) hits_q[s] <= '0;
			else if (rd_vld_s1 && hit[s]) hits_q[s] <= hits_q[s] + FW'(1);
		end
		if (cmd.accept) begin
			res_q.fired_mask <= '0;
			res_q.status     <= acc_status;
			res_q.new_slot   <= acc_slot;
		end else if (cmd.finish) begin
			res_q.fired_mask <= mask;
			res_q.status     <= ST_OK;
			res_q.new_slot   <= '0;
		end
	end

	assign result = res_q;
	assign done   = done_q;

endmodule

>>> design/windowed_light_event_detector.sv
// Top level of the windowed light event detector.
//
//  channel   | signals                    | transfer
//  ----------+----------------------------+------------------------------
//  request   | start, busy, request       | start && !busy
//  result    | done, result               | done high for one cycle
//  config    | cfg_valid, cfg_ready, data | cfg_valid && cfg_ready
//
// Sample request: the ring memory read port scans the filled entries one entry per cycle,
//   then the controller passes through its drain and finish states before done.
// Create, destroy and unused requests: done in the cycle after accept.
// busy is low again in the done cycle, so a new request may enter then.
// Reset clears the slot table valid bits, fill count and write position at once.
// The receiver cannot stall; cfg_ready is always high.
module windowed_light_event_detector #(
	parameter int WINDOW_DEPTH = wlevd_pkg::DEF_WINDOW_DEPTH,
	parameter int EVENT_SLOTS  = wlevd_pkg::DEF_EVENT_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  wlevd_pkg::request_t            request,
	output logic                           done,
	output wlevd_pkg::result_t             result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wlevd_pkg::MARGIN_W-1:0] cfg_data
);
	import wlevd_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t sts;

	assign cfg_ready = 1'b1;

	wlevd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	wlevd_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.EVENT_SLOTS  (EVENT_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.request  (request),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.result   (result),
		.done     (done)
	);

endmodule

>>> design/wlevd_checker.sv
// Port-level assertions for the windowed light event detector, with bind.
module wlevd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input wlevd_pkg::request_t request,
	input logic                done,
	input wlevd_pkg::result_t  result
);
	import wlevd_pkg::*;

	a_ctl_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (request.command != CMD_SAMPLE) |=> done && !busy)
		else $error("table request did not complete in one cycle");

	a_smp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (request.command == CMD_SAMPLE) |=> busy && !done)
		else $error("sample request did not start a scan");

	a_mask_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_OK) |-> (result.fired_mask == '0))
		else $error("fired mask set on failed request");

	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_FULL) |-> (result.new_slot == '0))
		else $error("slot index reported on full table");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while still busy");

endmodule

bind windowed_light_event_detector wlevd_checker u_wlevd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);

>>> test/testbench.sv
// Self-checking testbench for the windowed light event detector: directed and random requests.
`timescale 1ns / 100ps

module testbench;
	import wlevd_pkg::*;

	localparam int DEPTH = DEF_WINDOW_DEPTH;
	localparam int SLOTS = DEF_EVENT_SLOTS;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 700;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	logic cfg_valid;
	logic cfg_ready;
	logic [MARGIN_W-1:0] cfg_data;
	request_t request;
	result_t result;

	windowed_light_event_detector DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// mirror of the detector state
	logic signed [SMP_W-1:0] ring_mirror [DEPTH];
	int unsigned ring_fill;
	int unsigned ring_wr;
	bit slot_live [SLOTS];
	logic signed [SMP_W-1:0] slot_level [SLOTS];
	int unsigned slot_need [SLOTS];
	logic [MARGIN_W-1:0] margin;

	result_t expected_results [$];
	int errors;
	bit no_gaps;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("testbench NOT OK");
		$finish;
	end

	function automatic result_t detect(request_t req);
		result_t res;
		longint lim;
		longint v;
		int unsigned hits;
		int unsigned need;
		bit found;
		res = '0;
		found = 1'b0;
		case (req.command)
		CMD_SAMPLE: begin
			ring_mirror[ring_wr] = req.intensity;
			ring_wr = (ring_wr + 1) % DEPTH;
			if (ring_fill < DEPTH)
				ring_fill++;
			for (int s = 0; s < SLOTS; s++) begin
				if (slot_live[s]) begin
					lim = longint'(slot_level[s]) - longint'(margin);
					hits = 0;
					for (int k = 0; k < ring_fill; k++) begin
						v = longint'(ring_mirror[k]);
						if (v > lim)
							hits++;
					end
					if (hits >= slot_need[s])
						res.fired_mask[s] = 1'b1;
				end
			end
		end
		CMD_CREATE: begin
			for (int s = 0; s < SLOTS; s++) begin
				if (!found && !slot_live[s]) begin
					need = 32'(req.min_count);
					if (need > DEPTH)
						need = DEPTH;
					slot_live[s] = 1'b1;
					slot_level[s] = req.required_intensity;
					slot_need[s] = need;
					res.new_slot = SLOT_W'(s);
					found = 1'b1;
				end
			end
			if (!found)
				res.status = ST_FULL;
		end
		CMD_DESTROY: begin
			if (slot_live[req.event_slot])
				slot_live[req.event_slot] = 1'b0;
			else
				res.status = ST_UNKNOWN;
		end
		default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result.fired_mask !== want.fired_mask) begin
					$error("fired_mask expected %h actual %h", want.fired_mask, result.fired_mask);
					errors++;
				end
				if (result.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, result.status);
					errors++;
				end
				if (result.new_slot !== want.new_slot) begin
					$error("new_slot expected %0d actual %0d", want.new_slot, result.new_slot);
					errors++;
				end
			end
		end
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CNT_W-1:0] any_count();
		return CNT_W'($urandom);
	endfunction

	function automatic logic [SLOT_W-1:0] any_slot();
		return SLOT_W'($urandom);
	endfunction

	function automatic request_t make_req(logic [CMD_W-1:0] cmd, logic [SMP_W-1:0] level,
		logic [CNT_W-1:0] count, logic [SLOT_W-1:0] slot);
		request_t req;
		req.command = cmd;
		req.intensity = (cmd == CMD_SAMPLE) ? level : $urandom;
		req.required_intensity = (cmd == CMD_CREATE) ? level : $urandom;
		req.min_count = count;
		req.event_slot = slot;
		return req;
	endfunction

	// inputs change on the falling edge; caller is just past a falling edge
	task automatic send(request_t req);
		int gap;
		gap = idle_gap();
		request = req;
		start = 1'b1;
		do @(posedge clk); while (busy);
		expected_results.push_back(detect(req));
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_margin(logic [MARGIN_W-1:0] value);
		start = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		margin = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [SMP_W-1:0] rand_level();
		case ($urandom_range(0, 9))
		0: return $urandom;
		1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
		default: return $urandom_range(0, 400) - 200;
		endcase
	endfunction

	function automatic logic [SLOT_W-1:0] live_or_any();
		logic [SLOT_W-1:0] pick;
		pick = SLOT_W'($urandom);
		if ($urandom_range(0, 4) != 0)
			for (int n = 0; n < SLOTS && !slot_live[pick]; n++)
				pick++;
		return pick;
	endfunction

	task automatic test_empty_table();
		send(make_req(CMD_SAMPLE, 32'h7fffffff, any_count(), any_slot()));
		send(make_req(CMD_DESTROY, $urandom, any_count(), 3'd0));
		send(make_req(CMD_UNUSED, $urandom, any_count(), any_slot()));
	endtask

	task automatic test_slot_table();
		send(make_req(CMD_CREATE, 32'h80000000, 16'd0, any_slot()));
		send(make_req(CMD_CREATE, 32'h7fffffff, 16'd16, any_slot()));
		send(make_req(CMD_CREATE, 32'd0, 16'hffff, any_slot()));
		send(make_req(CMD_CREATE, 32'hffffffff, 16'd1, any_slot()));
		send(make_req(CMD_CREATE, 32'd100, 16'd17, any_slot()));
		repeat (3) send(make_req(CMD_CREATE, rand_level(), CNT_W'($urandom_range(0, 4)),
			any_slot()));
		// table full
		send(make_req(CMD_CREATE, $urandom, any_count(), any_slot()));
		send(make_req(CMD_DESTROY, $urandom, any_count(), 3'd3));
		send(make_req(CMD_DESTROY, $urandom, any_count(), 3'd3));
		send(make_req(CMD_CREATE, 32'd100, 16'd2, any_slot()));
	endtask

	task automatic test_sample_extremes();
		send(make_req(CMD_SAMPLE, 32'h80000000, any_count(), any_slot()));
		send(make_req(CMD_SAMPLE, 32'h7fffffff, any_count(), any_slot()));
		send(make_req(CMD_SAMPLE, 32'd0, any_count(), any_slot()));
		send(make_req(CMD_SAMPLE, 32'hffffffff, any_count(), any_slot()));
		// threshold 100 less margin 20: 80 misses, 81 hits
		send(make_req(CMD_SAMPLE, 32'd80, any_count(), any_slot()));
		send(make_req(CMD_SAMPLE, 32'd81, any_count(), any_slot()));
	endtask

	task automatic test_noise_margin();
		write_margin(16'd0);
		send(make_req(CMD_SAMPLE, 32'd100, any_count(), any_slot()));
		write_margin(16'hffff);
		send(make_req(CMD_SAMPLE, 32'h7fff0000, any_count(), any_slot()));
		write_margin(NOISE_MARGIN_RST);
	endtask

	task automatic test_random();
		int r;
		logic [CNT_W-1:0] count;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 99) begin
				case ($urandom_range(0, 3))
				0: write_margin(16'd0);
				1: write_margin(16'hffff);
				2: write_margin(MARGIN_W'($urandom_range(0, 100)));
				default: write_margin(MARGIN_W'($urandom));
				endcase
				no_gaps = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			count = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom)
				: CNT_W'($urandom_range(0, DEPTH + 1));
			if (r < 65)
				send(make_req(CMD_SAMPLE, rand_level(), any_count(), any_slot()));
			else if (r < 80)
				send(make_req(CMD_CREATE, rand_level(), count, any_slot()));
			else if (r < 95)
				send(make_req(CMD_DESTROY, $urandom, any_count(), live_or_any()));
			else
				send(make_req(CMD_UNUSED, $urandom, any_count(), any_slot()));
		end
	endtask

	initial begin
		errors = 0;
		no_gaps = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		margin = NOISE_MARGIN_RST;
		ring_fill = 0;
		ring_wr = 0;
		ring_mirror = '{default: '0};
		slot_live = '{default: 1'b0};
		slot_level = '{default: '0};
		slot_need = '{default: 0};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_slot_table();
		test_sample_extremes();
		test_noise_margin();
		test_random();

		start = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
design/wlevd_pkg.sv
design/wlevd_ctrl.sv
design/wlevd_datapath.sv
design/windowed_light_event_detector.sv
design/wlevd_checker.sv
test/testbench.sv
